@@ src/iofs_pkg.sv @@
// ---------------------------------------------------------------------------
// iofs_pkg
// types, register codes and helper functions of the synthetic imu block
// ---------------------------------------------------------------------------
package iofs_pkg;

   typedef struct packed {
      logic               values_valid;
      logic [62:0]        pose_ns;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
   } req_type;

   typedef struct packed {
      logic [62:0]        out_pose_ns;
      logic signed [15:0] out_quat_x;
      logic signed [15:0] out_quat_y;
      logic signed [15:0] out_quat_z;
      logic signed [15:0] out_quat_w;
      logic signed [31:0] out_rate_x;
      logic signed [31:0] out_rate_y;
      logic signed [31:0] out_rate_z;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
      logic               motion_added;
   } rsp_type;

   localparam logic [7:0]  CSR_GRAVITY    = 8'd0;
   localparam logic [7:0]  CSR_MAX_STEP   = 8'd1;
   localparam logic [21:0] GRAVITY_RESET  = 22'd642253;
   localparam logic [31:0] MAX_STEP_RESET = 32'd100000000;
   localparam logic [31:0] NS_PER_S       = 32'd1000000000;
   localparam logic [62:0] MIN_STEP_NS    = 63'd10000;

   localparam logic [5:0] CNT_QUAT  = 6'd16;
   localparam logic [5:0] CNT_GRAV  = 6'd22;
   localparam logic [5:0] CNT_NS    = 6'd30;
   localparam logic [5:0] CNT_CROSS = 6'd32;
   localparam logic [6:0] DIV_STEPS = 7'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      STP_XX, STP_YY, STP_ZZ, STP_WW,
      STP_XZ, STP_WY, STP_YZ, STP_WX,
      STP_GX, STP_DX, STP_GY, STP_DY, STP_GZ, STP_DZ,
      STP_FX, STP_QX, STP_FY, STP_QY, STP_FZ, STP_QZ,
      STP_C1X, STP_C2X, STP_C1Y, STP_C2Y, STP_C1Z, STP_C2Z
   } step_type;

   typedef struct packed {
      logic       start;
      logic       neg;
      logic [5:0] count;
   } mul_cmd_type;

   typedef struct packed {
      logic start;
      logic neg;
   } div_cmd_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? (64'd0 - 64'(v)) : 64'(v);
   endfunction

   // q32.32 to q16.16, round half away from zero
   function automatic logic signed [63:0] rq16(input logic signed [63:0] v);
      logic [63:0] q;
      q = (mag64(v) + 64'h8000) >> 16;
      return v[63] ? signed'(64'd0 - q) : signed'(q);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

@@ src/iofs_mul.sv @@
// ---------------------------------------------------------------------------
// iofs_mul
// shift-add multiplier, one multiplier bit per cycle, sign applied at the end
// ---------------------------------------------------------------------------
module iofs_mul
   import iofs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   input  logic [63:0] a_mag,
   input  logic [31:0] b_mag,
   output logic        done,
   output logic [63:0] prod
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] sum;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      sum     = b_ff[0] ? (acc_ff + a_ff) : acc_ff;
      if (cmd.start) begin
         acc_in  = 64'd0;
         a_in    = a_mag;
         b_in    = b_mag;
         cnt_in  = cmd.count;
         busy_in = 1'b1;
         neg_in  = cmd.neg;
      end else if (busy_ff) begin
         acc_in = sum;
         a_in   = {a_ff[62:0], 1'b0};
         b_in   = {1'b0, b_ff[31:1]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            prod_in = neg_ff ? (64'd0 - sum) : sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

@@ src/iofs_div.sv @@
// ---------------------------------------------------------------------------
// iofs_div
// restoring divider, one quotient bit per cycle, sign applied at the end
// ---------------------------------------------------------------------------
module iofs_div
   import iofs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   input  logic [63:0] num,
   input  logic [32:0] den,
   output logic        done,
   output logic [63:0] quo
);

   logic [32:0] rem_ff, rem_in;
   logic [63:0] num_ff, num_in;
   logic [32:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [63:0] quo_ff, quo_in;
   logic [33:0] trial;
   logic [33:0] diff;
   logic        fits;
   logic [63:0] q_next;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      trial   = {rem_ff, num_ff[63]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      q_next  = {num_ff[62:0], fits};
      if (cmd.start) begin
         rem_in  = 33'd0;
         num_in  = num;
         den_in  = den;
         cnt_in  = DIV_STEPS;
         busy_in = 1'b1;
         neg_in  = cmd.neg;
      end else if (busy_ff) begin
         rem_in = fits ? diff[32:0] : trial[32:0];
         num_in = q_next;
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? (64'd0 - q_next) : q_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ src/imu_from_odometry_synth.sv @@
// ---------------------------------------------------------------------------
// imu_from_odometry_synth
// synthetic imu word from a pose word: gravity rotated into the body frame,
// plus finite-difference acceleration and omega x v when the step allows
// ---------------------------------------------------------------------------
//  channel  ports                                  direction
//  req      req_valid, req_stall, req_data         in, pose word
//  rsp      rsp_valid, rsp_stall, rsp_data         out, imu word
//  csr      csr_valid, csr_ready, csr_index/data   in, register write
//
//  one word at a time through a sequencer over a bit-serial multiplier and a
//  bit-serial divider, more steps with the motion term, fewer for a zero
//  quaternion; a word with values_valid low is dropped while idle. synchronous
//  reset clears control and previous-sample state, resets the csr registers.
//  a finished word waits in the output register while the next word is taken;
//  the sequencer holds only if that register is full and rsp_stall is high.
// ---------------------------------------------------------------------------
module imu_from_odometry_synth
   import iofs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   state_type          state_ff, state_in;
   step_type           step_ff, step_in;
   req_type            item_ff, item_in;
   logic [62:0]        d_ff, d_in;
   logic               borrow_ff, borrow_in;
   logic               have_last_ff, have_last_in;
   logic [62:0]        last_stamp_ff, last_stamp_in;
   logic signed [31:0] last_vx_ff, last_vx_in;
   logic signed [31:0] last_vy_ff, last_vy_in;
   logic signed [31:0] last_vz_ff, last_vz_in;
   logic [21:0]        gravity_ff, gravity_in;
   logic [31:0]        max_step_ff, max_step_in;
   logic [32:0]        n2_ff, n2_in;
   logic [31:0]        sxy_ff, sxy_in;
   logic signed [32:0] ex_ff, ex_in;
   logic signed [32:0] ey_ff, ey_in;
   logic signed [63:0] t_ff, t_in;
   logic signed [63:0] ax_ff, ax_in;
   logic signed [63:0] ay_ff, ay_in;
   logic signed [63:0] az_ff, az_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   mul_cmd_type        mul_cmd;
   div_cmd_type        div_cmd;
   logic signed [63:0] op_a, op_b;
   logic [63:0]        mul_a;
   logic [63:0]        mag_b;
   logic [5:0]         mul_count;
   logic [63:0]        div_num;
   logic [32:0]        div_den;
   logic               mul_done, div_done;
   logic [63:0]        mul_prod, div_quo;
   logic signed [63:0] res;
   logic               is_div;
   logic               motion;
   logic [63:0]        d_full;

   assign is_div = step_ff inside {STP_DX, STP_DY, STP_DZ, STP_QX, STP_QY, STP_QZ};
   assign motion = have_last_ff && !borrow_ff && (d_ff > MIN_STEP_NS)
                   && (d_ff <= 63'(max_step_ff));
   assign res    = signed'(mul_done ? mul_prod : div_quo);

   // operand selection
   always_comb begin
      op_a      = 64'sd0;
      op_b      = 64'sd0;
      mul_count = CNT_QUAT;
      div_den   = n2_ff;
      case (step_ff)
         STP_XX: begin op_a = 64'(item_ff.quat_x); op_b = 64'(item_ff.quat_x); end
         STP_YY: begin op_a = 64'(item_ff.quat_y); op_b = 64'(item_ff.quat_y); end
         STP_ZZ: begin op_a = 64'(item_ff.quat_z); op_b = 64'(item_ff.quat_z); end
         STP_WW: begin op_a = 64'(item_ff.quat_w); op_b = 64'(item_ff.quat_w); end
         STP_XZ: begin op_a = 64'(item_ff.quat_x); op_b = 64'(item_ff.quat_z); end
         STP_WY: begin op_a = 64'(item_ff.quat_w); op_b = 64'(item_ff.quat_y); end
         STP_YZ: begin op_a = 64'(item_ff.quat_y); op_b = 64'(item_ff.quat_z); end
         STP_WX: begin op_a = 64'(item_ff.quat_w); op_b = 64'(item_ff.quat_x); end
         STP_GX: begin
            op_a = 64'(ex_ff) <<< 1; op_b = signed'(64'(gravity_ff)); mul_count = CNT_GRAV;
         end
         STP_GY: begin
            op_a = 64'(ey_ff) <<< 1; op_b = signed'(64'(gravity_ff)); mul_count = CNT_GRAV;
         end
         STP_GZ: begin
            op_a = signed'(64'(n2_ff)) - signed'(64'(sxy_ff) << 1);
            op_b = signed'(64'(gravity_ff));
            mul_count = CNT_GRAV;
         end
         STP_FX: begin
            op_a = 64'(item_ff.vel_x) - 64'(last_vx_ff);
            op_b = signed'(64'(NS_PER_S)); mul_count = CNT_NS;
         end
         STP_FY: begin
            op_a = 64'(item_ff.vel_y) - 64'(last_vy_ff);
            op_b = signed'(64'(NS_PER_S)); mul_count = CNT_NS;
         end
         STP_FZ: begin
            op_a = 64'(item_ff.vel_z) - 64'(last_vz_ff);
            op_b = signed'(64'(NS_PER_S)); mul_count = CNT_NS;
         end
         STP_QX, STP_QY, STP_QZ: div_den = {1'b0, d_ff[31:0]};
         STP_C1X: begin
            op_a = 64'(item_ff.rate_y); op_b = 64'(item_ff.vel_z); mul_count = CNT_CROSS;
         end
         STP_C2X: begin
            op_a = 64'(item_ff.rate_z); op_b = 64'(item_ff.vel_y); mul_count = CNT_CROSS;
         end
         STP_C1Y: begin
            op_a = 64'(item_ff.rate_z); op_b = 64'(item_ff.vel_x); mul_count = CNT_CROSS;
         end
         STP_C2Y: begin
            op_a = 64'(item_ff.rate_x); op_b = 64'(item_ff.vel_z); mul_count = CNT_CROSS;
         end
         STP_C1Z: begin
            op_a = 64'(item_ff.rate_x); op_b = 64'(item_ff.vel_y); mul_count = CNT_CROSS;
         end
         STP_C2Z: begin
            op_a = 64'(item_ff.rate_y); op_b = 64'(item_ff.vel_x); mul_count = CNT_CROSS;
         end
         default: ;
      endcase
      mul_a   = mag64(op_a);
      mag_b   = mag64(op_b);
      div_num = mag64(t_ff) + 64'(div_den >> 1);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      item_in       = item_ff;
      d_in          = d_ff;
      borrow_in     = borrow_ff;
      have_last_in  = have_last_ff;
      last_stamp_in = last_stamp_ff;
      last_vx_in    = last_vx_ff;
      last_vy_in    = last_vy_ff;
      last_vz_in    = last_vz_ff;
      gravity_in    = gravity_ff;
      max_step_in   = max_step_ff;
      n2_in         = n2_ff;
      sxy_in        = sxy_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      t_in          = t_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      az_in         = az_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      mul_cmd       = '{start: 1'b0, neg: op_a[63] ^ op_b[63], count: mul_count};
      div_cmd       = '{start: 1'b0, neg: t_ff[63]};
      d_full        = {1'b0, req_data.pose_ns} - {1'b0, last_stamp_ff};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_GRAVITY:  gravity_in  = csr_data[21:0];
            CSR_MAX_STEP: max_step_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.values_valid) begin
               item_in   = req_data;
               d_in      = d_full[62:0];
               borrow_in = d_full[63];
               n2_in     = 33'd0;
               sxy_in    = 32'd0;
               step_in   = STP_XX;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (is_div) begin
               div_cmd.start = 1'b1;
            end else begin
               mul_cmd.start = 1'b1;
            end
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (mul_done || div_done) begin
               state_in = ST_LOAD;
               case (step_ff)
                  STP_XX: begin
                     n2_in = n2_ff + res[32:0]; sxy_in = sxy_ff + res[31:0]; step_in = STP_YY;
                  end
                  STP_YY: begin
                     n2_in = n2_ff + res[32:0]; sxy_in = sxy_ff + res[31:0]; step_in = STP_ZZ;
                  end
                  STP_ZZ: begin n2_in = n2_ff + res[32:0]; step_in = STP_WW; end
                  STP_WW: begin n2_in = n2_ff + res[32:0]; step_in = STP_XZ; end
                  STP_XZ: begin ex_in = res[32:0]; step_in = STP_WY; end
                  STP_WY: begin ex_in = ex_ff - res[32:0]; step_in = STP_YZ; end
                  STP_YZ: begin ey_in = res[32:0]; step_in = STP_WX; end
                  STP_WX: begin
                     ey_in = ey_ff + res[32:0];
                     if (n2_ff == 33'd0) begin
                        ax_in = 64'sd0;
                        ay_in = 64'sd0;
                        az_in = signed'(64'(gravity_ff));
                        if (motion) begin
                           step_in = STP_FX;
                        end else begin
                           state_in = ST_DONE;
                        end
                     end else begin
                        step_in = STP_GX;
                     end
                  end
                  STP_GX: begin t_in = res; step_in = STP_DX; end
                  STP_DX: begin ax_in = res; step_in = STP_GY; end
                  STP_GY: begin t_in = res; step_in = STP_DY; end
                  STP_DY: begin ay_in = res; step_in = STP_GZ; end
                  STP_GZ: begin t_in = res; step_in = STP_DZ; end
                  STP_DZ: begin
                     az_in = res;
                     if (motion) begin
                        step_in = STP_FX;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  STP_FX: begin t_in = res; step_in = STP_QX; end
                  STP_QX: begin ax_in = ax_ff + res; step_in = STP_FY; end
                  STP_FY: begin t_in = res; step_in = STP_QY; end
                  STP_QY: begin ay_in = ay_ff + res; step_in = STP_FZ; end
                  STP_FZ: begin t_in = res; step_in = STP_QZ; end
                  STP_QZ: begin az_in = az_ff + res; step_in = STP_C1X; end
                  STP_C1X: begin t_in = res; step_in = STP_C2X; end
                  STP_C2X: begin ax_in = ax_ff + rq16(t_ff - res); step_in = STP_C1Y; end
                  STP_C1Y: begin t_in = res; step_in = STP_C2Y; end
                  STP_C2Y: begin ay_in = ay_ff + rq16(t_ff - res); step_in = STP_C1Z; end
                  STP_C1Z: begin t_in = res; step_in = STP_C2Z; end
                  STP_C2Z: begin
                     az_in    = az_ff + rq16(t_ff - res);
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.out_pose_ns  = item_ff.pose_ns;
               rsp_in.out_quat_x   = item_ff.quat_x;
               rsp_in.out_quat_y   = item_ff.quat_y;
               rsp_in.out_quat_z   = item_ff.quat_z;
               rsp_in.out_quat_w   = item_ff.quat_w;
               rsp_in.out_rate_x   = item_ff.rate_x;
               rsp_in.out_rate_y   = item_ff.rate_y;
               rsp_in.out_rate_z   = item_ff.rate_z;
               rsp_in.accel_x      = sat32(ax_ff);
               rsp_in.accel_y      = sat32(ay_ff);
               rsp_in.accel_z      = sat32(az_ff);
               rsp_in.motion_added = motion;
               last_stamp_in       = item_ff.pose_ns;
               last_vx_in          = item_ff.vel_x;
               last_vy_in          = item_ff.vel_y;
               last_vz_in          = item_ff.vel_z;
               have_last_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STP_XX;
         have_last_ff  <= 1'b0;
         last_stamp_ff <= 63'd0;
         last_vx_ff    <= 32'sd0;
         last_vy_ff    <= 32'sd0;
         last_vz_ff    <= 32'sd0;
         gravity_ff    <= GRAVITY_RESET;
         max_step_ff   <= MAX_STEP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         have_last_ff  <= have_last_in;
         last_stamp_ff <= last_stamp_in;
         last_vx_ff    <= last_vx_in;
         last_vy_ff    <= last_vy_in;
         last_vz_ff    <= last_vz_in;
         gravity_ff    <= gravity_in;
         max_step_ff   <= max_step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff   <= item_in;
      d_ff      <= d_in;
      borrow_ff <= borrow_in;
      n2_ff     <= n2_in;
      sxy_ff    <= sxy_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      t_ff      <= t_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      az_ff     <= az_in;
      rsp_ff    <= rsp_in;
   end

   iofs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .a_mag (mul_a),
      .b_mag (mag_b[31:0]),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   iofs_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
